// File: hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// 1-Wire bus master package
// Shared types, register indexes, reset values and fixed timing limits of the
// tick-driven 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // Widths fixed by the beat formats and the register file.
  localparam int unsigned CfgW         = 10;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned NumCfg       = 8;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned BitCntW      = 4;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutDataW     = 16;

  // Default tick timer width.
  localparam int unsigned TimerBitsDef = 10;

  // Wait limits in ticks for the line to come back high.
  localparam int unsigned WaitBeforeReset = 250;
  localparam int unsigned WaitAfterReset  = 410;
  localparam int unsigned WaitBeforeSlot  = 10;

  // Slots in one byte.
  localparam logic [BitCntW-1:0] BitsPerByte = BitCntW'(8);

  // Commands carried in the input beat.
  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpReset = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgResetLow     = 3'd0,
    CfgPresenceSmp  = 3'd1,
    CfgWriteOneLow  = 3'd2,
    CfgWriteZeroLow = 3'd3,
    CfgWriteSlot    = 3'd4,
    CfgReadLow      = 3'd5,
    CfgReadSmpDelay = 3'd6,
    CfgReadTail     = 3'd7
  } cfg_idx_e;

  // Reset values of the configuration registers, by index.
  typedef logic [CfgW-1:0] cfg_word_t;
  localparam cfg_word_t CfgResetVal [NumCfg] = '{
    cfg_word_t'(480), cfg_word_t'(70), cfg_word_t'(10), cfg_word_t'(65),
    cfg_word_t'(65),  cfg_word_t'(2),  cfg_word_t'(11), cfg_word_t'(48)
  };

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhWaitPre   = 4'd1,
    PhGuardPre  = 4'd2,
    PhRstLow    = 4'd3,
    PhRstRel    = 4'd4,
    PhWaitPost  = 4'd5,
    PhGuardPost = 4'd6,
    PhWaitSlot  = 4'd7,
    PhGuardSlot = 4'd8,
    PhWrLow     = 4'd9,
    PhWrHigh    = 4'd10,
    PhWrRecov   = 4'd11,
    PhRdLow     = 4'd12,
    PhRdDelay   = 4'd13,
    PhRdTail    = 4'd14
  } phase_e;

  // Result beat fields.
  typedef struct packed {
    logic             status;
    logic             presence;
    logic [ByteW-1:0] read_data;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// 1-Wire bus master
// Tick-driven 1-Wire master: one input beat per bus tick, one result beat out
// per tick with the line drive and the command status.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_axis    in         opcode[1:0], write_byte[9:2], line_level[10]
//   m_axis    out        drive_low[0], busy_res[1], done_res[2],
//                        read_data[10:3], presence[11], status[12]
//   cfg       in         write enable, register index, 10-bit data
//
// The sequencer state and the output stage are updated in the cycle the
// input beat is accepted, so one beat per cycle is sustained while the skid
// register is empty. A two-entry output stage (result register plus skid
// register) keeps s_axis_tready registered; it drops only when both entries
// are full. Reset clears the sequencer to idle and loads the default timings.
`default_nettype none

module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // opcode[1:0], write_byte[9:2], line_level[10], zero fill above
  input  wire logic [InDataW-1:0]  s_axis_tdata,

  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence[11],
  // status[12], zero fill above
  output      logic [OutDataW-1:0] m_axis_tdata,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i
);

  // Compare width covers both the timer and the register values plus a carry.
  localparam int unsigned CmpW = ((TIMER_BITS > CfgW) ? TIMER_BITS : CfgW) + 1;
  localparam logic [CmpW-1:0] TimerMax = CmpW'((64'd1 << TIMER_BITS) - 64'd1);

  // Saturate a register value to what the timer can count.
  function automatic logic [CmpW-1:0] sat_f(input logic [CfgW-1:0] t);
    logic [CmpW-1:0] v;
    v = CmpW'(t);
    return (v > TimerMax) ? TimerMax : v;
  endfunction

  // A timed phase lasts at least one tick.
  function automatic logic [CmpW-1:0] eff_f(input logic [CmpW-1:0] t);
    return (t == '0) ? CmpW'(1) : t;
  endfunction

  // Input beat fields.
  opcode_e          opcode;
  logic [ByteW-1:0] write_byte;
  logic             line_level;

  assign opcode     = opcode_e'(s_axis_tdata[1:0]);
  assign write_byte = s_axis_tdata[9:2];
  assign line_level = s_axis_tdata[10];

  // Configuration registers.
  logic [CfgW-1:0] cfg_q [NumCfg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cfg_q[i] <= CfgResetVal[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  // Sequencer state.
  phase_e                phase_q, phase_d;
  opcode_e               kind_q, kind_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [ByteW-1:0]      shift_q, shift_d;
  logic [BitCntW-1:0]    bits_q, bits_d;
  logic                  pres_q, pres_d;
  logic                  stat_q, stat_d;
  logic [ByteW-1:0]      hold_q, hold_d;
  logic                  done_d;

  // Timing values for the current phase.
  logic [CmpW-1:0]    wlow_eff, wslot_sat, whigh, limit, timer_inc;
  logic               limit_hit;
  logic [BitCntW-1:0] bits_nx;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign wlow_eff  = eff_f(sat_f(shift_q[0] ? cfg_q[CfgWriteOneLow] : cfg_q[CfgWriteZeroLow]));
  assign wslot_sat = sat_f(cfg_q[CfgWriteSlot]);
  assign whigh     = (wslot_sat > wlow_eff) ? (wslot_sat - wlow_eff) : '0;
  assign timer_inc = CmpW'(timer_q) + CmpW'(1);
  assign bits_nx   = bits_q + BitCntW'(1);

  // Duration or wait limit of the current phase, one shared comparator.
  always_comb begin
    case (phase_q)
      PhWaitPre:  limit = CmpW'(WaitBeforeReset);
      PhWaitPost: limit = CmpW'(WaitAfterReset);
      PhWaitSlot: limit = CmpW'(WaitBeforeSlot);
      PhRstLow:   limit = eff_f(sat_f(cfg_q[CfgResetLow]));
      PhRstRel:   limit = eff_f(sat_f(cfg_q[CfgPresenceSmp]));
      PhWrLow:    limit = wlow_eff;
      PhWrHigh:   limit = eff_f(whigh);
      PhRdLow:    limit = eff_f(sat_f(cfg_q[CfgReadLow]));
      PhRdDelay:  limit = eff_f(sat_f(cfg_q[CfgReadSmpDelay]));
      PhRdTail:   limit = eff_f(sat_f(cfg_q[CfgReadTail]));
      default:    limit = CmpW'(1);
    endcase
  end

  assign limit_hit = (timer_inc >= limit);

  // Next-state logic of the sequencer for one tick.
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    timer_d = timer_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    pres_d  = pres_q;
    stat_d  = stat_q;
    hold_d  = hold_q;
    done_d  = 1'b0;

    case (phase_q)
      PhIdle: begin
        if (opcode != OpTick) begin
          kind_d  = opcode;
          stat_d  = 1'b0;
          bits_d  = '0;
          timer_d = '0;
          shift_d = (opcode == OpWrite) ? write_byte : '0;
          if (opcode == OpReset) begin
            pres_d  = 1'b0;
            phase_d = PhWaitPre;
          end else begin
            phase_d = PhWaitSlot;
          end
        end
      end
      PhWaitPre, PhWaitPost, PhWaitSlot: begin
        if (line_level) begin
          timer_d = '0;
          case (phase_q)
            PhWaitPre:  phase_d = PhGuardPre;
            PhWaitPost: phase_d = PhGuardPost;
            default:    phase_d = PhGuardSlot;
          endcase
        end else if (limit_hit) begin
          // Line stuck low: end the command with a timeout.
          stat_d  = 1'b1;
          if (kind_q == OpReset) begin
            pres_d = 1'b0;
          end
          phase_d = PhIdle;
          timer_d = '0;
          done_d  = 1'b1;
        end else begin
          timer_d = timer_inc[TIMER_BITS-1:0];
        end
      end
      PhGuardPre: begin
        phase_d = PhRstLow;
        timer_d = '0;
      end
      PhGuardPost: begin
        phase_d = PhIdle;
        timer_d = '0;
        done_d  = 1'b1;
      end
      PhGuardSlot: begin
        phase_d = (kind_q == OpWrite) ? PhWrLow : PhRdLow;
        timer_d = '0;
      end
      PhRstLow, PhRstRel, PhWrLow, PhWrHigh, PhRdLow, PhRdDelay, PhRdTail: begin
        if (!limit_hit) begin
          timer_d = timer_inc[TIMER_BITS-1:0];
        end else begin
          timer_d = '0;
          case (phase_q)
            PhRstLow: phase_d = PhRstRel;
            PhRstRel: begin
              pres_d  = ~line_level;
              phase_d = PhWaitPost;
            end
            PhWrLow:  phase_d = (whigh != '0) ? PhWrHigh : PhWrRecov;
            PhWrHigh: phase_d = PhWrRecov;
            PhRdLow:  phase_d = PhRdDelay;
            default: begin
              // Sample the read bit at the end of the delay, then end the slot
              // here or after the tail.
              if (phase_q == PhRdDelay) begin
                shift_d = {line_level, shift_q[ByteW-1:1]};
              end
              if (phase_q == PhRdDelay && sat_f(cfg_q[CfgReadTail]) != '0) begin
                phase_d = PhRdTail;
              end else begin
                bits_d = bits_nx;
                if (bits_nx >= BitsPerByte) begin
                  if (kind_q == OpRead) begin
                    hold_d = shift_d;
                  end
                  phase_d = PhIdle;
                  done_d  = 1'b1;
                end else begin
                  phase_d = PhWaitSlot;
                end
              end
            end
          endcase
        end
      end
      PhWrRecov: begin
        // Recovery tick of a write slot: shift out the sent bit.
        shift_d = {1'b0, shift_q[ByteW-1:1]};
        bits_d  = bits_nx;
        timer_d = '0;
        if (bits_nx >= BitsPerByte) begin
          phase_d = PhIdle;
          done_d  = 1'b1;
        end else begin
          phase_d = PhWaitSlot;
        end
      end
      default: begin
        phase_d = PhIdle;
        timer_d = '0;
      end
    endcase
  end

  // Result fields for this tick.
  result_t res;

  always_comb begin
    res.drive_low = phase_q inside {PhRstLow, PhWrLow, PhRdLow};
    res.busy_res  = (phase_d != PhIdle);
    res.done_res  = done_d;
    res.read_data = hold_d;
    res.presence  = pres_d;
    res.status    = stat_d;
  end

  // Sequencer registers advance on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      kind_q  <= OpTick;
      timer_q <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      pres_q  <= 1'b0;
      stat_q  <= 1'b0;
      hold_q  <= '0;
    end else if (in_beat) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      pres_q  <= pres_d;
      stat_q  <= stat_d;
      hold_q  <= hold_d;
    end
  end

  // Output stage: result register with a skid register behind it.
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_pop;

  assign out_pop       = out_valid_q && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_beat) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_beat) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the tick-driven 1-Wire bus master
// Sends one tick beat per bus tick, shapes the sampled line level from the
// predicted bus phase and checks every result beat against a predictor of the
// sequencer or a directed table entry. The run covers a directed table, then
// random command traffic under several timing settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import owbm_pkg::*;

  localparam int CycleLimit = 1_000_000;

  // One row of the directed table; reps of zero runs ticks until the command ends.
  typedef struct packed {
    opcode_e     op;
    logic [7:0]  wb;
    logic        ln;
    logic [9:0]  reps;
    logic        typed;
    result_t     want;
  } dir_row_t;

  function automatic result_t res_word(logic busy, logic done, logic [7:0] rd,
                                       logic pr, logic st);
    result_t r;
    r = '0;
    r.busy_res  = busy;
    r.done_res  = done;
    r.read_data = rd;
    r.presence  = pr;
    r.status    = st;
    return r;
  endfunction

  localparam result_t AllLow = '0;

  // Directed table, run with the reset timings.
  localparam dir_row_t DirRows [9] = '{
    '{OpTick,  8'h00, 1'b1, 10'd1,   1'b1, AllLow},  // state after reset
    '{OpTick,  8'hFF, 1'b0, 10'd1,   1'b1, AllLow},  // tick only ignores the byte
    '{OpReset, 8'h00, 1'b0, 10'd1,   1'b1, res_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b0)},
    '{OpTick,  8'h00, 1'b0, 10'd249, 1'b0, AllLow},
    // Line never rises before the reset pulse.
    '{OpTick,  8'h00, 1'b0, 10'd1,   1'b1, res_word(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)},
    // Stuck line before a read slot keeps the old read byte.
    '{OpRead,  8'h00, 1'b0, 10'd1,   1'b0, AllLow},
    '{OpTick,  8'h00, 1'b0, 10'd9,   1'b0, AllLow},
    '{OpTick,  8'h00, 1'b0, 10'd1,   1'b1, res_word(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)},
    // The timeout status stays visible while idle.
    '{OpTick,  8'h00, 1'b1, 10'd1,   1'b1, res_word(1'b0, 1'b0, 8'h00, 1'b0, 1'b1)}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // opcode[1:0], write_byte[9:2], line_level[10], zero fill above
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence[11],
  // status[12], zero fill above
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  one_wire_bus_master i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run state shared between the sender, the receiver and the checks.
  result_t pending_res [$];
  int      n_err = 0;
  int      n_cmd_items = 0;
  int      snd_idle_pct = 11;
  int      rcv_idle_pct = 66;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  bit      stuck_mode = 1'b0;
  int      stuck_left = 0;
  int      cyc = 0;

  // Predicted sequencer state and timing registers.
  phase_e                  ph = PhIdle;
  opcode_e                 cmd = OpTick;
  logic [TimerBitsDef-1:0] tmr = '0;
  logic [ByteW-1:0]        shreg = '0;
  logic [BitCntW-1:0]      nbits = '0;
  logic                    pres = 1'b0;
  logic                    stat = 1'b0;
  logic [ByteW-1:0]        rd_hold = '0;
  logic                    done_now = 1'b0;
  cfg_word_t               tim [NumCfg] = CfgResetVal;

  function automatic int min1(cfg_word_t t);
    return (t == 0) ? 1 : int'(t);
  endfunction

  // Counts one tick of a timed phase; returns 1 on its last tick.
  function automatic bit timer_done(cfg_word_t t);
    int n;
    n = int'(tmr) + 1;
    if (n >= min1(t)) begin
      tmr = '0;
      return 1'b1;
    end
    tmr = TimerBitsDef'(n);
    return 1'b0;
  endfunction

  function automatic cfg_word_t wr_low();
    return shreg[0] ? tim[CfgWriteOneLow] : tim[CfgWriteZeroLow];
  endfunction

  function automatic int wr_high();
    int lo;
    lo = min1(wr_low());
    return (int'(tim[CfgWriteSlot]) > lo) ? int'(tim[CfgWriteSlot]) - lo : 0;
  endfunction

  task automatic end_cmd();
    ph = PhIdle;
    tmr = '0;
    done_now = 1'b1;
  endtask

  // Waits for a high line; a line low for the whole limit ends the command.
  task automatic await_high(input logic ln, input int limit, input phase_e nxt);
    int n;
    if (ln) begin
      ph = nxt;
      tmr = '0;
    end else begin
      n = int'(tmr) + 1;
      if (n >= limit) begin
        stat = 1'b1;
        if (cmd == OpReset) pres = 1'b0;
        end_cmd();
      end else begin
        tmr = TimerBitsDef'(n);
      end
    end
  endtask

  task automatic slot_end();
    nbits = nbits + 1'b1;
    tmr = '0;
    if (nbits >= BitsPerByte) begin
      if (cmd == OpRead) rd_hold = shreg;
      end_cmd();
    end else begin
      ph = PhWaitSlot;
    end
  endtask

  // Advances the predicted master by one tick and returns its result beat.
  task automatic bus_tick(input opcode_e op, input logic [7:0] wb, input logic ln,
                          output result_t r);
    logic drv;
    drv = 1'b0;
    done_now = 1'b0;
    case (ph)
      PhIdle: begin
        if (op != OpTick) begin
          cmd = op;
          stat = 1'b0;
          nbits = '0;
          tmr = '0;
          shreg = (op == OpWrite) ? wb : 8'h00;
          if (op == OpReset) begin
            pres = 1'b0;
            ph = PhWaitPre;
          end else begin
            ph = PhWaitSlot;
          end
        end
      end
      PhWaitPre: await_high(ln, WaitBeforeReset, PhGuardPre);
      PhGuardPre: begin
        ph = PhRstLow;
        tmr = '0;
      end
      PhRstLow: begin
        drv = 1'b1;
        if (timer_done(tim[CfgResetLow])) ph = PhRstRel;
      end
      PhRstRel: begin
        if (timer_done(tim[CfgPresenceSmp])) begin
          pres = ~ln;
          ph = PhWaitPost;
        end
      end
      PhWaitPost: await_high(ln, WaitAfterReset, PhGuardPost);
      PhGuardPost: end_cmd();
      PhWaitSlot: await_high(ln, WaitBeforeSlot, PhGuardSlot);
      PhGuardSlot: begin
        ph = (cmd == OpWrite) ? PhWrLow : PhRdLow;
        tmr = '0;
      end
      PhWrLow: begin
        drv = 1'b1;
        if (timer_done(wr_low())) ph = (wr_high() > 0) ? PhWrHigh : PhWrRecov;
      end
      PhWrHigh: begin
        if (timer_done(cfg_word_t'(wr_high()))) ph = PhWrRecov;
      end
      PhWrRecov: begin
        shreg = shreg >> 1;
        slot_end();
      end
      PhRdLow: begin
        drv = 1'b1;
        if (timer_done(tim[CfgReadLow])) ph = PhRdDelay;
      end
      PhRdDelay: begin
        if (timer_done(tim[CfgReadSmpDelay])) begin
          shreg = {ln, shreg[7:1]};
          if (tim[CfgReadTail] == 0) slot_end();
          else ph = PhRdTail;
        end
      end
      PhRdTail: begin
        if (timer_done(tim[CfgReadTail])) slot_end();
      end
      default: begin
        ph = PhIdle;
        tmr = '0;
      end
    endcase
    r = '0;
    r.drive_low = drv;
    r.busy_res  = (ph != PhIdle);
    r.done_res  = done_now;
    r.read_data = rd_hold;
    r.presence  = pres;
    r.status    = stat;
  endtask

  // Offers one input beat and returns at the edge that accepts it.
  task automatic send_beat(input logic [InDataW-1:0] d);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic issue(input opcode_e op, input logic [7:0] wb, input logic ln,
                       input logic typed, input result_t want);
    result_t r;
    send_beat({5'b00000, ln, wb, op});
    bus_tick(op, wb, ln, r);
    pending_res.push_back(typed ? want : r);
  endtask

  // Line level for the next tick, shaped by the predicted phase.
  task automatic pick_line(output logic ln);
    case (ph)
      PhWaitPre, PhWaitPost, PhWaitSlot: begin
        if (stuck_mode && stuck_left == 0 && $urandom_range(0, 4) == 0)
          stuck_left = $urandom_range(4, 14);
        if (stuck_left > 0) begin
          stuck_left--;
          ln = 1'b0;
        end else begin
          ln = ($urandom_range(0, 7) != 0);
        end
      end
      default: ln = 1'($urandom_range(0, 1));
    endcase
  endtask

  // Starts one command and ticks it to its end, with stray commands mixed in.
  task automatic run_command(input opcode_e op);
    logic ln;
    opcode_e rop;
    stuck_mode = ($urandom_range(0, 3) == 0);
    stuck_left = 0;
    issue(op, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, AllLow);
    n_cmd_items++;
    while (ph != PhIdle) begin
      pick_line(ln);
      rop = ($urandom_range(0, 7) == 0) ? opcode_e'($urandom_range(0, 3)) : OpTick;
      issue(rop, 8'($urandom), ln, 1'b0, AllLow);
      n_cmd_items++;
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = n_cmd_items;
    while (n_cmd_items - start < budget) begin
      repeat ($urandom_range(0, 2))
        issue(OpTick, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, AllLow);
      run_command(opcode_e'($urandom_range(1, 3)));
    end
  endtask

  // Stops offering beats and waits until every result beat is back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(input cfg_word_t v [NumCfg]);
    for (int i = 0; i < NumCfg; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_idx_e'(i);
      cfg_wdata_i <= v[i];
      tim[i] = v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  task automatic check_beat(input logic [OutDataW-1:0] d);
    result_t want;
    result_t got;
    if (pending_res.size() == 0) begin
      $error("result beat %h with no expectation waiting", d);
      n_err++;
    end else begin
      want = pending_res.pop_front();
      got = result_t'(d[12:0]);
      check_field("drive_low", want.drive_low, got.drive_low);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("done_res", want.done_res, got.done_res);
      check_field("read_data", want.read_data, got.read_data);
      check_field("presence", want.presence, got.presence);
      check_field("status", want.status, got.status);
      check_field("zero fill", 0, d[OutDataW-1:13]);
    end
  endtask

  // Result side: check accepted beats, then choose the next ready level.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Cycle limit.
  initial begin
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    cfg_word_t vals [NumCfg];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset timings.
    foreach (DirRows[k]) begin
      if (DirRows[k].reps == 0) begin
        do issue(DirRows[k].op, DirRows[k].wb, DirRows[k].ln, 1'b0, AllLow);
        while (ph != PhIdle);
      end else begin
        for (int j = 0; j < int'(DirRows[k].reps); j++)
          issue(DirRows[k].op, DirRows[k].wb, DirRows[k].ln,
                DirRows[k].typed && (j == int'(DirRows[k].reps) - 1), DirRows[k].want);
      end
    end
    wait_drained();

    // All timings at zero: every timed phase collapses to its shortest form.
    foreach (vals[i]) vals[i] = '0;
    set_timing(vals);
    run_random(40);
    wait_drained();

    // Short random timings with the sender mostly idle.
    snd_idle_pct = 66;
    rcv_idle_pct = 11;
    foreach (vals[i]) vals[i] = cfg_word_t'($urandom_range(0, 3));
    set_timing(vals);
    run_random(50);
    wait_drained();

    // Full rate, with a long receiver hold-off at the start.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    foreach (vals[i]) vals[i] = cfg_word_t'($urandom_range(0, 3));
    set_timing(vals);
    hold_req = 1'b1;
    run_random(50);
    wait_drained();
    repeat (12) @(posedge clk_i);

    if (n_err == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/owbm_pkg.sv
hw/rtl/one_wire_bus_master.sv
sim/tb.sv
